// ===== src/voxel_span_bounding_box_defines.svh =====
// Assertion macros for the voxel span bounding box block.
// Clock clk_i and active-low reset rst_ni are taken from the using scope.
`ifndef VOXEL_SPAN_BOUNDING_BOX_DEFINES_SVH
`define VOXEL_SPAN_BOUNDING_BOX_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define VSBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vsbb: same-cycle check failed");
// Next-cycle implication
`define VSBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vsbb: next-cycle check failed");
`else
`define VSBB_ASSERT_IMP(label, ante, cons)
`define VSBB_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/vsbb_pkg.sv =====
// Shared types and constants for the voxel span bounding box block.
// No dependencies.
`timescale 1ns / 1ps

package vsbb_pkg;

  localparam int unsigned VoxelSizeDefault  = 256;
  localparam int unsigned VoxelSizeZDefault = 256;

  localparam int unsigned LenW   = 31;  // data_length and byte position
  localparam int unsigned WordW  = 32;
  localparam int unsigned CoordW = 9;   // y and z indices, 0..256
  localparam int unsigned HdrLen = 8;   // row header bytes, also span room needed

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_START  = 3'd1,
    PH_END    = 3'd2,
    PH_COLOUR = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  typedef struct packed {
    logic signed [WordW-1:0]  min_x;
    logic signed [WordW-1:0]  max_x;
    logic        [CoordW-1:0] min_y;
    logic        [CoordW-1:0] max_y;
    logic        [CoordW-1:0] min_z;
    logic        [CoordW-1:0] max_z;
  } result_t;

endpackage

// ===== src/vsbb_in_if.sv =====
// Input channel of the voxel span bounding box: one span data byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface vsbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== src/vsbb_out_if.sv =====
// Result channel of the voxel span bounding box: one bounding box per item.
// Depends on vsbb_pkg for the field widths.
`timescale 1ns / 1ps

interface vsbb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vsbb_pkg::WordW-1:0]    min_x;
  logic signed [vsbb_pkg::WordW-1:0]    max_x;
  logic        [vsbb_pkg::CoordW-1:0]   min_y;
  logic        [vsbb_pkg::CoordW-1:0]   max_y;
  logic        [vsbb_pkg::CoordW-1:0]   min_z;
  logic        [vsbb_pkg::CoordW-1:0]   max_z;

  modport source (output valid, output min_x, output max_x, output min_y, output max_y,
                  output min_z, output max_z, input ready);
  modport sink   (input valid, input min_x, input max_x, input min_y, input max_y,
                  input min_z, input max_z, output ready);
endinterface

// ===== src/voxel_span_bounding_box.sv =====
// Voxel span bounding box: byte-wise span stream parser with min/max tracking.
// Depends on vsbb_pkg, vsbb_in_if, vsbb_out_if and voxel_span_bounding_box_defines.svh.
//
// Usage
//   item_i   : valid/ready stream of span data bytes; last marks the final byte
//              of a pass. An item is taken on a clock edge with valid && ready.
//   result_o : valid/ready stream carrying the bounding box of a pass, one
//              result per item with last set.
//   cfg_we_i / cfg_data_i : writes data_length (bytes in the pass). Write only
//              while no result is outstanding.
// Timing
//   One item per cycle while item_i.ready is high. All parsing for a byte is
//   a single pass of counters, one 33-bit add/compare and the min/max
//   compares, straight into the parse registers; a last item's result is
//   registered into result_o, or into the skid register if result_o is full.
// Stalls
//   Results go through an output register backed by a one-entry skid
//   register, so bytes keep flowing while a result waits. Only with both
//   holding a result does item_i.ready drop, until the sink takes one.
// Reset
//   rst_ni clears parse state, bounds, data_length and both result slots.
//   After each result the parse state and bounds go back to reset values;
//   data_length is kept.
`timescale 1ns / 1ps
`include "voxel_span_bounding_box_defines.svh"

module voxel_span_bounding_box #(
  parameter int unsigned VOXEL_SIZE   = vsbb_pkg::VoxelSizeDefault,
  parameter int unsigned VOXEL_SIZE_Z = vsbb_pkg::VoxelSizeZDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vsbb_pkg::LenW-1:0] cfg_data_i,
  vsbb_in_if.sink                   item_i,
  vsbb_out_if.source                result_o
);

  localparam int unsigned LenW   = vsbb_pkg::LenW;
  localparam int unsigned WordW  = vsbb_pkg::WordW;
  localparam int unsigned CoordW = vsbb_pkg::CoordW;

  localparam logic [WordW-1:0]  LowXRst = WordW'(VOXEL_SIZE);
  localparam logic [CoordW-1:0] LowYRst = CoordW'(VOXEL_SIZE);
  localparam logic [CoordW-1:0] LowZRst = CoordW'(VOXEL_SIZE_Z);
  localparam logic [WordW-1:0]  HdrLenW = WordW'(vsbb_pkg::HdrLen);

  // configuration
  logic [LenW-1:0] dlen_q;

  // parse state
  vsbb_pkg::phase_e   phase_q, phase_d;
  logic [LenW-1:0]    bytes_q, bytes_d;
  logic [WordW-1:0]   wa_q, wa_d;
  logic [3:0]         bif_q, bif_d;
  logic [WordW-1:0]   rbc_q, rbc_d;
  logic [WordW-1:0]   spans_q, spans_d;
  logic [WordW-1:0]   body_q, body_d;
  logic [WordW-1:0]   start_q, start_d;
  logic [CoordW-1:0]  row_q, row_d;
  logic [CoordW-1:0]  layer_q, layer_d;
  logic               stopped_q, stopped_d;

  // bounds
  logic [WordW-1:0]   low_x_q, low_x_d, high_x_q, high_x_d;
  logic [CoordW-1:0]  low_y_q, low_y_d, high_y_q, high_y_d;
  logic [CoordW-1:0]  low_z_q, low_z_d, high_z_q, high_z_d;

  // output register and skid
  logic               out_valid_q, skid_valid_q;
  vsbb_pkg::result_t  out_q, skid_q, res_new;

  logic               accept, push, pop;
  logic               do_dispatch, do_next_row;
  logic [WordW-1:0]   wa_new;
  logic [3:0]         bif_n;
  logic [WordW:0]     reach;       // byte position after the row body
  logic [CoordW-1:0]  row_inc;

  assign accept = item_i.valid && item_i.ready;
  assign push   = accept && item_i.last;
  assign pop    = out_valid_q && result_o.ready;

  assign item_i.ready = !skid_valid_q;

  assign wa_new = wa_q | ({{(WordW-8){1'b0}}, item_i.data_byte} << {bif_q[1:0], 3'b000});
  assign bif_n  = bif_q + 4'd1;
  assign reach  = {1'b0, {(WordW-LenW){1'b0}}, bytes_d} + {1'b0, rbc_q - HdrLenW};

  // ---- per-byte parse step ----
  always_comb begin
    phase_d     = phase_q;
    bytes_d     = bytes_q;
    wa_d        = wa_q;
    bif_d       = bif_q;
    rbc_d       = rbc_q;
    spans_d     = spans_q;
    body_d      = body_q;
    start_d     = start_q;
    row_d       = row_q;
    layer_d     = layer_q;
    stopped_d   = stopped_q;
    low_x_d     = low_x_q;
    high_x_d    = high_x_q;
    low_y_d     = low_y_q;
    high_y_d    = high_y_q;
    low_z_d     = low_z_q;
    high_z_d    = high_z_q;
    do_dispatch = 1'b0;
    do_next_row = 1'b0;
    row_inc     = row_q + CoordW'(1);

    if (!stopped_q) begin
      if (bytes_q >= dlen_q) begin
        stopped_d = 1'b1;
      end else begin
        bytes_d = bytes_q + LenW'(1);
        case (phase_q)
          vsbb_pkg::PH_SKIP, vsbb_pkg::PH_COLOUR: begin
            body_d = body_q - WordW'(1);
            if (phase_q == vsbb_pkg::PH_COLOUR || body_d == '0) begin
              do_dispatch = 1'b1;
            end
          end
          default: begin
            bif_d = bif_n;
            if (bif_n[1:0] != 2'd0) begin
              wa_d = wa_new;
            end else begin
              wa_d = '0;
              case (phase_q)
                vsbb_pkg::PH_HEADER: begin
                  if (bif_n == 4'd4) begin
                    rbc_d = wa_new;
                  end else begin
                    spans_d = wa_new;
                    if (rbc_q == '0 || wa_new == '0) begin
                      do_next_row = 1'b1;
                    end else if (rbc_q < HdrLenW || reach > {1'b0, {(WordW-LenW){1'b0}}, dlen_q}) begin
                      stopped_d = 1'b1;
                    end else begin
                      body_d      = rbc_q - HdrLenW;
                      do_dispatch = 1'b1;
                    end
                  end
                end
                vsbb_pkg::PH_START: begin
                  start_d = wa_new;
                  phase_d = vsbb_pkg::PH_END;
                  bif_d   = 4'd0;
                end
                vsbb_pkg::PH_END: begin
                  // span taken: widen the box
                  if ($signed(start_q) < $signed(low_x_q)) low_x_d = start_q;
                  if ($signed(wa_new) > $signed(high_x_q)) high_x_d = wa_new;
                  if (row_q < low_y_q)   low_y_d  = row_q;
                  if (row_q > high_y_q)  high_y_d = row_q;
                  if (layer_q < low_z_q)  low_z_d  = layer_q;
                  if (layer_q > high_z_q) high_z_d = layer_q;
                  spans_d = spans_q - WordW'(1);
                  body_d  = body_q - HdrLenW;
                  bif_d   = 4'd0;
                  if (body_d != '0) begin
                    phase_d = vsbb_pkg::PH_COLOUR;
                  end else begin
                    do_dispatch = 1'b1;
                  end
                end
                default: begin
                  stopped_d = stopped_q;
                end
              endcase
            end
          end
        endcase
      end
    end

    // choose what follows the row header, a span, its colour byte or the skip bytes
    if (do_dispatch) begin
      bif_d = 4'd0;
      if (spans_d != '0 && body_d >= HdrLenW) begin
        phase_d = vsbb_pkg::PH_START;
      end else if (body_d != '0) begin
        phase_d = vsbb_pkg::PH_SKIP;
      end else begin
        do_next_row = 1'b1;
      end
    end

    // advance y, wrapping into z
    if (do_next_row) begin
      phase_d = vsbb_pkg::PH_HEADER;
      bif_d   = 4'd0;
      if (32'(row_inc) >= VOXEL_SIZE) begin
        row_d   = '0;
        layer_d = layer_q + CoordW'(1);
      end else begin
        row_d = row_inc;
      end
      if (32'(layer_d) >= VOXEL_SIZE_Z) stopped_d = 1'b1;
    end
  end

  // result of this pass, taken from the bounds after the current byte
  always_comb begin
    if ($signed(low_x_d) > $signed(high_x_d)) begin
      res_new = '0;
    end else begin
      res_new.min_x = low_x_d;
      res_new.max_x = high_x_d;
      res_new.min_y = low_y_d;
      res_new.max_y = high_y_d;
      res_new.min_z = low_z_d;
      res_new.max_z = high_z_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q <= '0;
    end else if (cfg_we_i) begin
      dlen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= vsbb_pkg::PH_HEADER;
      bytes_q   <= '0;
      wa_q      <= '0;
      bif_q     <= '0;
      rbc_q     <= '0;
      spans_q   <= '0;
      body_q    <= '0;
      start_q   <= '0;
      row_q     <= '0;
      layer_q   <= '0;
      stopped_q <= 1'b0;
      low_x_q   <= LowXRst;
      high_x_q  <= '0;
      low_y_q   <= LowYRst;
      high_y_q  <= '0;
      low_z_q   <= LowZRst;
      high_z_q  <= '0;
    end else if (push) begin
      // pass done: back to a clean slate
      phase_q   <= vsbb_pkg::PH_HEADER;
      bytes_q   <= '0;
      wa_q      <= '0;
      bif_q     <= '0;
      rbc_q     <= '0;
      spans_q   <= '0;
      body_q    <= '0;
      start_q   <= '0;
      row_q     <= '0;
      layer_q   <= '0;
      stopped_q <= 1'b0;
      low_x_q   <= LowXRst;
      high_x_q  <= '0;
      low_y_q   <= LowYRst;
      high_y_q  <= '0;
      low_z_q   <= LowZRst;
      high_z_q  <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      bytes_q   <= bytes_d;
      wa_q      <= wa_d;
      bif_q     <= bif_d;
      rbc_q     <= rbc_d;
      spans_q   <= spans_d;
      body_q    <= body_d;
      start_q   <= start_d;
      row_q     <= row_d;
      layer_q   <= layer_d;
      stopped_q <= stopped_d;
      low_x_q   <= low_x_d;
      high_x_q  <= high_x_d;
      low_y_q   <= low_y_d;
      high_y_q  <= high_y_d;
      low_z_q   <= low_z_d;
      high_z_q  <= high_z_d;
    end
  end

  // ---- output register + skid ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.min_x = out_q.min_x;
  assign result_o.max_x = out_q.max_x;
  assign result_o.min_y = out_q.min_y;
  assign result_o.max_y = out_q.max_y;
  assign result_o.min_z = out_q.min_z;
  assign result_o.max_z = out_q.max_z;

  // ---- checks ----
  `VSBB_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `VSBB_ASSERT_IMP(a_body_phase_has_bytes,
                   phase_q == vsbb_pkg::PH_SKIP || phase_q == vsbb_pkg::PH_COLOUR, body_q != '0)
  `VSBB_ASSERT_NXT(a_stopped_holds_position, stopped_q && !push, $stable(bytes_q) && stopped_q)

endmodule

// ===== tb/voxel_span_bounding_box_checker.sv =====
// Scoreboard for the voxel span bounding box: tracks data_length and follows the byte stream
// to predict each pass's bounding box, then compares against the result channel.
// Depends on vsbb_pkg, vsbb_in_if and vsbb_out_if.
`timescale 1ns / 1ps

module voxel_span_bounding_box_checker
  import vsbb_pkg::*;
#(
  parameter int unsigned VOXEL_SIZE   = VoxelSizeDefault,
  parameter int unsigned VOXEL_SIZE_Z = VoxelSizeZDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_data_i,
  vsbb_in_if              item_i,
  vsbb_out_if             res_i,
  output int              fail_count_o,
  output int              outstanding_o
);

  // shadow of data_length
  logic [LenW-1:0]   span_len;

  // parser state
  phase_e            phase;
  logic [LenW-1:0]   consumed;
  logic [WordW-1:0]  word_acc;
  logic [3:0]        field_byte;
  logic [WordW-1:0]  row_len;
  logic [WordW-1:0]  spans_due;
  logic [WordW-1:0]  body_left;
  logic [WordW-1:0]  start_word;
  int unsigned       row_y;
  int unsigned       layer_z;
  bit                halted;

  // running bounds
  logic [WordW-1:0]  lo_x, hi_x;
  logic [CoordW-1:0] lo_y, hi_y, lo_z, hi_z;

  result_t           box_q[$];
  result_t           want;

  function automatic void clear_pass();
    phase      = PH_HEADER;
    consumed   = '0;
    word_acc   = '0;
    field_byte = '0;
    row_len    = '0;
    spans_due  = '0;
    body_left  = '0;
    start_word = '0;
    row_y      = 0;
    layer_z    = 0;
    halted     = 1'b0;
    lo_x       = WordW'(VOXEL_SIZE);
    hi_x       = '0;
    lo_y       = CoordW'(VOXEL_SIZE);
    hi_y       = '0;
    lo_z       = CoordW'(VOXEL_SIZE_Z);
    hi_z       = '0;
  endfunction

  function automatic void next_row();
    row_y++;
    if (row_y >= VOXEL_SIZE) begin
      row_y = 0;
      layer_z++;
    end
    if (layer_z >= VOXEL_SIZE_Z) halted = 1'b1;
    phase      = PH_HEADER;
    field_byte = '0;
  endfunction

  // pick what follows in the row body: a span, skip bytes or the next row
  function automatic void route_body();
    field_byte = '0;
    if (spans_due != 0 && body_left >= HdrLen) begin
      phase = PH_START;
    end else if (body_left != 0) begin
      phase = PH_SKIP;
    end else begin
      next_row();
    end
  endfunction

  function automatic void record_span(input logic [WordW-1:0] end_word);
    if ($signed(start_word) < $signed(lo_x)) lo_x = start_word;
    if ($signed(end_word) > $signed(hi_x)) hi_x = end_word;
    if (row_y < lo_y) lo_y = CoordW'(row_y);
    if (row_y > hi_y) hi_y = CoordW'(row_y);
    if (layer_z < lo_z) lo_z = CoordW'(layer_z);
    if (layer_z > hi_z) hi_z = CoordW'(layer_z);
  endfunction

  function automatic void eat_byte(input logic [7:0] b);
    logic [WordW-1:0] word;
    if (consumed >= span_len) begin
      halted = 1'b1;
      return;
    end
    consumed = consumed + 1'b1;

    if (phase == PH_SKIP || phase == PH_COLOUR) begin
      body_left = body_left - 1'b1;
      if (phase == PH_SKIP && body_left != 0) return;
      route_body();
      return;
    end

    word_acc   = word_acc | (WordW'(b) << (8 * field_byte[1:0]));
    field_byte = field_byte + 1'b1;
    if (field_byte[1:0] != 2'd0) return;
    word     = word_acc;
    word_acc = '0;

    case (phase)
      PH_HEADER: begin
        if (field_byte == 4'd4) begin
          row_len = word;
        end else begin
          spans_due = word;
          if (row_len == 0 || spans_due == 0) begin
            next_row();
          end else if (row_len < HdrLen ||
                       64'(consumed) + 64'(row_len - HdrLen) > 64'(span_len)) begin
            halted = 1'b1;
          end else begin
            body_left = row_len - HdrLen;
            route_body();
          end
        end
      end
      PH_START: begin
        start_word = word;
        phase      = PH_END;
        field_byte = '0;
      end
      default: begin
        record_span(word);
        spans_due  = spans_due - 1'b1;
        body_left  = body_left - HdrLen;
        field_byte = '0;
        if (body_left != 0) phase = PH_COLOUR;
        else route_body();
      end
    endcase
  endfunction

  function automatic result_t pass_box();
    result_t box;
    box = '0;
    if ($signed(lo_x) <= $signed(hi_x)) begin
      box.min_x = lo_x;
      box.max_x = hi_x;
      box.min_y = lo_y;
      box.max_y = hi_y;
      box.min_z = lo_z;
      box.max_z = hi_z;
    end
    return box;
  endfunction

  function automatic void match_field(input string tag, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag,
               $signed(exp_v), $signed(got_v));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_len = '0;
      clear_pass();
      box_q.delete();
      outstanding_o = 0;
      fail_count_o  = 0;
    end else begin
      // a byte taken on the same edge as a length write still sees the old length
      if (item_i.valid && item_i.ready) begin
        if (!halted) eat_byte(item_i.data_byte);
        if (item_i.last) begin
          box_q.push_back(pass_box());
          clear_pass();
        end
      end
      if (cfg_we_i) span_len = cfg_data_i;
      if (res_i.valid && res_i.ready) begin
        if (box_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no pass outstanding, expected none, actual min_x %0d",
                   $time, res_i.min_x);
        end else begin
          want = box_q.pop_front();
          match_field("min_x", want.min_x, res_i.min_x);
          match_field("max_x", want.max_x, res_i.max_x);
          match_field("min_y", 32'(want.min_y), 32'(res_i.min_y));
          match_field("max_y", 32'(want.max_y), 32'(res_i.max_y));
          match_field("min_z", 32'(want.min_z), 32'(res_i.min_z));
          match_field("max_z", 32'(want.max_z), 32'(res_i.max_z));
        end
      end
      outstanding_o = box_q.size();
    end
  end

endmodule

// ===== tb/voxel_span_bounding_box_tb.sv =====
// Top of the voxel span bounding box testbench: clock, reset, byte stimulus, result sink
// and the verdict. Depends on vsbb_pkg, both channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module voxel_span_bounding_box_tb;
  import vsbb_pkg::*;

  // About 750 items; the limit leaves a wide margin over the time they need, idle gaps,
  // stalls and settling included.
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomItems = 720;
  localparam int unsigned HoldCycles  = 200;  // long receiver hold-off
  localparam int unsigned DrainCycles = 4;    // the last item's result goes through the output register
  localparam logic [LenW-1:0] LenMax  = '1;

  logic            clk      = 1'b0;
  logic            rst_n    = 1'b0;
  logic            cfg_we   = 1'b0;
  logic [LenW-1:0] cfg_data = '0;
  int              fail_count;
  int              outstanding;
  int unsigned     cycle_cnt = 0;
  int unsigned     gap_pct   = 0;     // chance of an idle burst before each item, in %
  int unsigned     stall_pct = 0;     // chance of a receiver stall burst per cycle, in %
  bit              long_hold = 1'b0;  // set by stimulus, cleared by the receiver when done
  logic [7:0]      pass_q[$];         // bytes of the pass being built

  vsbb_in_if  item_ch ();
  vsbb_out_if res_ch ();

  voxel_span_bounding_box u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .item_i     (item_ch),
    .result_o   (res_ch)
  );

  voxel_span_bounding_box_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .item_i        (item_ch),
    .res_i         (res_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 2 ns clock
  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result sink. Random stall bursts while stall_pct is nonzero; on request a single long
  // hold-off so that both result slots fill and the block has to back-pressure its input.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        long_hold = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // One item: optional idle burst first, then hold valid until the handshake. Entered and
  // left at a falling edge; valid stays high on return so back-to-back items need no dip.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.data_byte <= b;
    item_ch.last      <= fin;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_pass(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(pass_q[i], i == n - 1);
  endtask

  // Drop valid, let every outstanding box come out, then wait DrainCycles more.
  task automatic settle();
    item_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // data_length write, only ever from an idle block
  task automatic set_span_length(input logic [LenW-1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) pass_q.push_back(w[8*i +: 8]);
  endfunction

  // span coordinate: mostly near the voxel range, sometimes negative, wide or extreme
  function automatic logic [31:0] rand_x();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 300);
      1:       return 32'd0 - $urandom_range(1, 300);
      2:       return $urandom();
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Well-formed row with k spans. Variants: skip bytes after the spans, the last span's
  // colour byte missing (exactly 8 bytes of room), span count above or below what fits.
  function automatic void add_good_row();
    int unsigned k, tail, body, spans;
    bit          clipped;
    k       = $urandom_range(0, 3);
    clipped = (k != 0) && ($urandom_range(0, 4) == 0);
    tail    = (!clipped && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    body    = 9 * k + tail - clipped;
    case ($urandom_range(0, 5))
      0:       spans = k + $urandom_range(1, 3);
      1:       spans = 32'hFFFF_FFFF;
      2:       spans = (k > 1) ? $urandom_range(1, k - 1) : 1;
      default: spans = (k == 0) ? 1 : k;
    endcase
    put_word(HdrLen + body);
    put_word(spans);
    for (int unsigned i = 0; i < k; i++) begin
      put_word(rand_x());
      put_word(rand_x());
      if (!(clipped && i == k - 1)) pass_q.push_back($urandom_range(0, 255));
    end
    repeat (tail) pass_q.push_back($urandom_range(0, 255));
  endfunction

  function automatic void add_row();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        // empty row: either header word zero, the other anything
        if ($urandom_range(0, 1) == 1) begin
          put_word(0);
          put_word($urandom());
        end else begin
          put_word(($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(1, 40));
          put_word(0);
        end
      end
      4: begin
        // byte count too small for a header
        put_word($urandom_range(1, 7));
        put_word($urandom_range(1, 9));
      end
      5: begin
        // body far longer than the bytes that follow
        put_word(32'h4000_0000 | $urandom());
        put_word($urandom_range(1, 4));
        repeat ($urandom_range(1, 6)) pass_q.push_back($urandom_range(0, 255));
      end
      6: repeat ($urandom_range(1, 6)) pass_q.push_back($urandom_range(0, 255));
      default: add_good_row();
    endcase
  endfunction

  // Random pass of a few rows, sometimes with trailing junk and a mismatched length.
  task automatic random_pass(inout int unsigned sent);
    int unsigned n;
    pass_q.delete();
    repeat ($urandom_range(1, 4)) add_row();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8)) pass_q.push_back($urandom_range(0, 255));
    end

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: set_span_length(LenW'(pass_q.size()));
      5:             set_span_length(LenW'($urandom_range(0, pass_q.size())));
      6:             set_span_length(LenW'(pass_q.size() + $urandom_range(1, 64)));
      7:             set_span_length(($urandom_range(0, 1) == 1) ? LenMax : '0);
      default:       ;  // keep whatever length is set
    endcase

    // now and then the pass is cut short by an early last
    n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, pass_q.size()) : pass_q.size();
    send_pass(n);
    sent += n;
  endtask

  initial begin
    int unsigned sent;
    sent = 0;
    item_ch.valid     = 1'b0;
    item_ch.data_byte = '0;
    item_ch.last      = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed ----
    gap_pct   = 20;
    stall_pct = 20;

    // zero length: the lone byte lies beyond data_length, so the box is empty
    set_span_length('0);
    pass_q.delete();
    pass_q.push_back(8'hFF);
    send_pass(1);

    // one span with the extreme signed start and end; last arrives on the end word,
    // before the colour byte, so the box reflects the partly parsed row
    set_span_length(LenW'(17));
    pass_q.delete();
    put_word(32'd17);
    put_word(32'd1);
    put_word(32'h8000_0000);
    put_word(32'h7FFF_FFFF);
    send_pass(pass_q.size());

    // ---- back-pressure: receiver holds off while single-byte passes keep coming ----
    settle();
    gap_pct   = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    repeat (12) send_byte($urandom_range(0, 255), 1'b1);
    settle();

    // ---- random passes; the last fifth runs with no idling at all ----
    while (sent < RandomItems) begin
      if (sent < RandomItems * 4 / 5) begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      random_pass(sent);
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
